// ----- rtl/rmc_pkg.sv -----
// Shared constants, control word types and the microcode ROM of the RSA byte cipher.
package rmc_pkg;

  // Arithmetic widths.
  localparam int MOD_BITS      = 32;
  localparam int EXP_BITS      = 31;
  localparam int VALUE_BITS    = 32;
  localparam int RESULT_BITS   = 32;
  localparam int STATUS_BITS   = 2;
  localparam int CNT_BITS      = $clog2(MOD_BITS);
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = (MOD_BITS > EXP_BITS) ? MOD_BITS : EXP_BITS;
  localparam int STEP_BITS     = 4;
  localparam int BYTE_BITS     = 8;
  localparam int BYTE_MAX      = 255;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_ENC_EXP = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEC_EXP = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [EXP_BITS-1:0] ENC_EXP_RST = EXP_BITS'(65537);
  localparam logic [EXP_BITS-1:0] DEC_EXP_RST = EXP_BITS'(1);
  localparam logic [MOD_BITS-1:0] MODULUS_RST = MOD_BITS'(1);

  // Action codes.
  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  // Status codes.
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_BIG   = 2'd2;

  // Datapath operation of one microcode step.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_TAKE,
    OP_CHECK,
    OP_MUL,
    OP_WAIT,
    OP_SHIFT,
    OP_FIN,
    OP_PUT
  } op_e;

  // Operand selection of the modular multiplier.
  typedef enum logic [1:0] {
    MS_RED,
    MS_MUL,
    MS_SQR
  } msel_e;

  // Jump condition of one microcode step.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_BEAT,
    C_SHORT,
    C_BIT_CLEAR,
    C_MUL_BUSY,
    C_EXP_MORE,
    C_OUT_BLOCKED
  } cond_e;

  typedef struct packed {
    op_e                  op;
    msel_e                msel;
    cond_e                cond;
    logic [STEP_BITS-1:0] target;
  } ctrl_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic short_path;
    logic exp_bit;
    logic exp_more;
    logic mul_busy;
  } dp_flags_t;

  // Step addresses of the program.
  localparam logic [STEP_BITS-1:0] PC_TAKE    = 4'd0;
  localparam logic [STEP_BITS-1:0] PC_CHECK   = 4'd1;
  localparam logic [STEP_BITS-1:0] PC_RED     = 4'd2;
  localparam logic [STEP_BITS-1:0] PC_RED_W   = 4'd3;
  localparam logic [STEP_BITS-1:0] PC_LOOP    = 4'd4;
  localparam logic [STEP_BITS-1:0] PC_MUL     = 4'd5;
  localparam logic [STEP_BITS-1:0] PC_MUL_W   = 4'd6;
  localparam logic [STEP_BITS-1:0] PC_SQR     = 4'd7;
  localparam logic [STEP_BITS-1:0] PC_SQR_W   = 4'd8;
  localparam logic [STEP_BITS-1:0] PC_SHIFT   = 4'd9;
  localparam logic [STEP_BITS-1:0] PC_FIN     = 4'd10;
  localparam logic [STEP_BITS-1:0] PC_PUT     = 4'd11;
  localparam logic [STEP_BITS-1:0] PC_RESTART = 4'd12;

  // Microcode ROM: a taken condition jumps to target, otherwise the step advances.
  function automatic ctrl_t ucode(logic [STEP_BITS-1:0] step);
    ctrl_t c;
    c = '{op: OP_NOP, msel: MS_RED, cond: C_ALWAYS, target: PC_TAKE};
    unique case (step)
      PC_TAKE:    c = '{op: OP_TAKE,  msel: MS_RED, cond: C_NO_BEAT,     target: PC_TAKE};
      PC_CHECK:   c = '{op: OP_CHECK, msel: MS_RED, cond: C_SHORT,       target: PC_FIN};
      PC_RED:     c = '{op: OP_MUL,   msel: MS_RED, cond: C_NEVER,       target: PC_TAKE};
      PC_RED_W:   c = '{op: OP_WAIT,  msel: MS_RED, cond: C_MUL_BUSY,    target: PC_RED_W};
      PC_LOOP:    c = '{op: OP_NOP,   msel: MS_RED, cond: C_BIT_CLEAR,   target: PC_SQR};
      PC_MUL:     c = '{op: OP_MUL,   msel: MS_MUL, cond: C_NEVER,       target: PC_TAKE};
      PC_MUL_W:   c = '{op: OP_WAIT,  msel: MS_MUL, cond: C_MUL_BUSY,    target: PC_MUL_W};
      PC_SQR:     c = '{op: OP_MUL,   msel: MS_SQR, cond: C_NEVER,       target: PC_TAKE};
      PC_SQR_W:   c = '{op: OP_WAIT,  msel: MS_SQR, cond: C_MUL_BUSY,    target: PC_SQR_W};
      PC_SHIFT:   c = '{op: OP_SHIFT, msel: MS_RED, cond: C_EXP_MORE,    target: PC_LOOP};
      PC_FIN:     c = '{op: OP_FIN,   msel: MS_RED, cond: C_NEVER,       target: PC_TAKE};
      PC_PUT:     c = '{op: OP_PUT,   msel: MS_RED, cond: C_OUT_BLOCKED, target: PC_PUT};
      PC_RESTART: c = '{op: OP_NOP,   msel: MS_RED, cond: C_ALWAYS,      target: PC_TAKE};
      default:    c = '{op: OP_NOP,   msel: MS_RED, cond: C_ALWAYS,      target: PC_TAKE};
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/rmc_if.sv -----
// Valid/ready channel interfaces for input and result beats.
interface rmc_in_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic [rmc_pkg::VALUE_BITS-1:0]    value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface rmc_out_if;
  logic                              valid;
  logic                              ready;
  logic [rmc_pkg::RESULT_BITS-1:0]   result;
  logic [rmc_pkg::STATUS_BITS-1:0]   status;

  modport source (output valid, output result, output status, input ready);
  modport sink   (input valid, input result, input status, output ready);
endinterface

// ----- rtl/rmc_mulmod.sv -----
// Bit-serial modular multiplier: double-and-add from the top bit, one add-mod per cycle.
module rmc_mulmod (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rmc_pkg::MOD_BITS-1:0] a_i,
  input  logic [rmc_pkg::MOD_BITS-1:0] b_i,
  input  logic [rmc_pkg::MOD_BITS-1:0] n_i,
  output logic                         busy_o,
  output logic [rmc_pkg::MOD_BITS-1:0] r_o
);

  logic                         busy_q;
  logic                         dbl_q;
  logic [rmc_pkg::CNT_BITS-1:0] cnt_q;
  logic [rmc_pkg::MOD_BITS-1:0] r_q;
  logic [rmc_pkg::MOD_BITS-1:0] a_q;
  logic [rmc_pkg::MOD_BITS-1:0] b_q;

  logic [rmc_pkg::MOD_BITS-1:0] addend;
  logic [rmc_pkg::MOD_BITS:0]   sum;
  logic [rmc_pkg::MOD_BITS:0]   n_ext;
  logic [rmc_pkg::MOD_BITS:0]   reduced;
  logic [rmc_pkg::MOD_BITS-1:0] r_next;

  // One shared add-mod: doubling phase adds r to itself, add phase adds a.
  always_comb begin
    addend  = dbl_q ? r_q : a_q;
    sum     = {1'b0, r_q} + {1'b0, addend};
    n_ext   = {1'b0, n_i};
    reduced = (sum >= n_ext) ? (sum - n_ext) : sum;
    r_next  = reduced[rmc_pkg::MOD_BITS-1:0];
  end

  // Phase and bit counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      dbl_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      dbl_q  <= 1'b1;
      cnt_q  <= rmc_pkg::CNT_BITS'(rmc_pkg::MOD_BITS - 1);
    end else if (busy_q) begin
      dbl_q <= !dbl_q;
      if (!dbl_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Partial result and operands.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= '0;
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      if (dbl_q) begin
        r_q <= r_next;
      end else begin
        if (b_q[rmc_pkg::MOD_BITS-1]) begin
          r_q <= r_next;
        end
        b_q <= {b_q[rmc_pkg::MOD_BITS-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign r_o    = r_q;

endmodule

// ----- rtl/rmc_datapath.sv -----
// Datapath of the cipher: item registers, exponent shifter, accumulator and multiplier.
module rmc_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rmc_pkg::ctrl_t                   ctrl_i,
  input  logic                             beat_i,
  input  logic                             action_i,
  input  logic [rmc_pkg::VALUE_BITS-1:0]   value_i,
  input  logic [rmc_pkg::EXP_BITS-1:0]     enc_exp_i,
  input  logic [rmc_pkg::EXP_BITS-1:0]     dec_exp_i,
  input  logic [rmc_pkg::MOD_BITS-1:0]     modulus_i,
  output rmc_pkg::dp_flags_t               flags_o,
  output logic [rmc_pkg::RESULT_BITS-1:0]  result_o,
  output logic [rmc_pkg::STATUS_BITS-1:0]  status_o
);

  logic                            action_q;
  logic [rmc_pkg::MOD_BITS-1:0]    value_q;
  logic [rmc_pkg::EXP_BITS-1:0]    exp_q;
  logic [rmc_pkg::MOD_BITS-1:0]    base_q;
  logic [rmc_pkg::MOD_BITS-1:0]    acc_q;
  logic [rmc_pkg::STATUS_BITS-1:0] status_q;

  logic                            small_n;
  logic                            bad_value;
  logic                            acc_big;
  logic                            mul_start;
  logic                            mul_busy;
  logic                            mul_done;
  logic [rmc_pkg::MOD_BITS-1:0]    mul_a;
  logic [rmc_pkg::MOD_BITS-1:0]    mul_b;
  logic [rmc_pkg::MOD_BITS-1:0]    mul_r;

  // Item checks: a modulus of zero or one gives zero; decrypt input must be below n.
  always_comb begin
    small_n   = (modulus_i[rmc_pkg::MOD_BITS-1:1] == '0);
    bad_value = (action_q == rmc_pkg::ACT_DECRYPT) && (value_q >= modulus_i);
    acc_big   = (acc_q > rmc_pkg::MOD_BITS'(rmc_pkg::BYTE_MAX));
  end

  // Multiplier operands: reduction is 1 times the value, then acc*base and base*base.
  always_comb begin
    unique case (ctrl_i.msel)
      rmc_pkg::MS_RED: begin
        mul_a = rmc_pkg::MOD_BITS'(1);
        mul_b = value_q;
      end
      rmc_pkg::MS_MUL: begin
        mul_a = acc_q;
        mul_b = base_q;
      end
      rmc_pkg::MS_SQR: begin
        mul_a = base_q;
        mul_b = base_q;
      end
      default: begin
        mul_a = base_q;
        mul_b = base_q;
      end
    endcase
    mul_start = (ctrl_i.op == rmc_pkg::OP_MUL);
    mul_done  = (ctrl_i.op == rmc_pkg::OP_WAIT) && !mul_busy;
  end

  rmc_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .n_i     (modulus_i),
    .busy_o  (mul_busy),
    .r_o     (mul_r)
  );

  // Item, exponent and result registers, updated by the current step's operation.
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      rmc_pkg::OP_TAKE: begin
        if (beat_i) begin
          action_q <= action_i;
          if (action_i == rmc_pkg::ACT_DECRYPT) begin
            value_q <= rmc_pkg::MOD_BITS'(value_i);
            exp_q   <= dec_exp_i;
          end else begin
            value_q <= rmc_pkg::MOD_BITS'(value_i[rmc_pkg::BYTE_BITS-1:0]);
            exp_q   <= enc_exp_i;
          end
        end
      end
      rmc_pkg::OP_CHECK: begin
        acc_q    <= small_n ? '0 : rmc_pkg::MOD_BITS'(1);
        status_q <= bad_value ? rmc_pkg::ST_RANGE : rmc_pkg::ST_OK;
      end
      rmc_pkg::OP_WAIT: begin
        if (mul_done) begin
          if (ctrl_i.msel == rmc_pkg::MS_MUL) begin
            acc_q <= mul_r;
          end else begin
            base_q <= mul_r;
          end
        end
      end
      rmc_pkg::OP_SHIFT: begin
        exp_q <= exp_q >> 1;
      end
      rmc_pkg::OP_FIN: begin
        // A flagged item reports zero; decrypted values above a byte are flagged.
        if (status_q != rmc_pkg::ST_OK) begin
          acc_q <= '0;
        end else if ((action_q == rmc_pkg::ACT_DECRYPT) && acc_big) begin
          acc_q    <= '0;
          status_q <= rmc_pkg::ST_BIG;
        end
      end
      rmc_pkg::OP_NOP, rmc_pkg::OP_MUL, rmc_pkg::OP_PUT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    flags_o.short_path = small_n || bad_value;
    flags_o.exp_bit    = exp_q[0];
    flags_o.exp_more   = (exp_q[rmc_pkg::EXP_BITS-1:1] != '0);
    flags_o.mul_busy   = mul_busy;
  end

  assign result_o = rmc_pkg::RESULT_BITS'(acc_q);
  assign status_o = status_q;

endmodule

// ----- rtl/rmc_sequencer.sv -----
// Microcode sequencer: step counter, control ROM and conditional jumps.
module rmc_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rmc_pkg::dp_flags_t flags_i,
  input  logic               beat_i,
  input  logic               out_blocked_i,
  output rmc_pkg::ctrl_t     ctrl_o
);

  logic [rmc_pkg::STEP_BITS-1:0] step_q;
  logic [rmc_pkg::STEP_BITS-1:0] step_d;
  rmc_pkg::ctrl_t                ctrl;
  logic                          taken;

  assign ctrl = rmc_pkg::ucode(step_q);

  // Evaluate the jump condition of the current step.
  always_comb begin
    unique case (ctrl.cond)
      rmc_pkg::C_NEVER:       taken = 1'b0;
      rmc_pkg::C_ALWAYS:      taken = 1'b1;
      rmc_pkg::C_NO_BEAT:     taken = !beat_i;
      rmc_pkg::C_SHORT:       taken = flags_i.short_path;
      rmc_pkg::C_BIT_CLEAR:   taken = !flags_i.exp_bit;
      rmc_pkg::C_MUL_BUSY:    taken = flags_i.mul_busy;
      rmc_pkg::C_EXP_MORE:    taken = flags_i.exp_more;
      rmc_pkg::C_OUT_BLOCKED: taken = out_blocked_i;
      default:                taken = 1'b1;
    endcase
    step_d = taken ? ctrl.target : step_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= rmc_pkg::PC_TAKE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

// ----- rtl/rsa_modexp_byte_cipher.sv -----
// Top level of the RSA byte cipher: configuration registers, handshakes and result register.
// Each input beat is encrypted (low byte raised to the public exponent mod n) or
// decrypted (value checked against n, raised to the private exponent, checked to fit a
// byte), and gives exactly one result beat. The block handles one item at a time under a
// microcoded sequencer; all arithmetic runs through one bit-serial modular multiplier
// that alternates doubling and adding over the bits of one operand, with a start step
// and a completion step around each product. An item is taken and checked, the base is
// reduced, then for every exponent bit up to the highest set one the bit is tested, the
// accumulator is multiplied by the base if the bit is set, the base is squared and the
// exponent shifted, and the result is finished. A decrypt input not below n or a modulus
// of zero or one goes straight to the finish. A finished result waits in an output
// register, so the next item is taken while it is not yet drained. Configuration writes
// are taken at any time but must only happen while the block is idle.
module rsa_modexp_byte_cipher (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rmc_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [rmc_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  rmc_in_if.sink                             in_i,
  rmc_out_if.source                          out_o
);

  logic [rmc_pkg::EXP_BITS-1:0]    enc_exp_q;
  logic [rmc_pkg::EXP_BITS-1:0]    dec_exp_q;
  logic [rmc_pkg::MOD_BITS-1:0]    modulus_q;

  logic                            out_valid_q;
  logic                            out_valid_d;
  logic [rmc_pkg::RESULT_BITS-1:0] out_result_q;
  logic [rmc_pkg::STATUS_BITS-1:0] out_status_q;

  rmc_pkg::ctrl_t                  ctrl;
  rmc_pkg::dp_flags_t              flags;
  logic                            beat;
  logic                            out_blocked;
  logic                            put;
  logic [rmc_pkg::RESULT_BITS-1:0] dp_result;
  logic [rmc_pkg::STATUS_BITS-1:0] dp_status;

  // Configuration registers; writes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_exp_q <= rmc_pkg::ENC_EXP_RST;
      dec_exp_q <= rmc_pkg::DEC_EXP_RST;
      modulus_q <= rmc_pkg::MODULUS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rmc_pkg::CFG_ENC_EXP: enc_exp_q <= cfg_data_i[rmc_pkg::EXP_BITS-1:0];
        rmc_pkg::CFG_DEC_EXP: dec_exp_q <= cfg_data_i[rmc_pkg::EXP_BITS-1:0];
        rmc_pkg::CFG_MODULUS: modulus_q <= cfg_data_i[rmc_pkg::MOD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake decode.
  always_comb begin
    in_i.ready  = (ctrl.op == rmc_pkg::OP_TAKE);
    beat        = in_i.valid && in_i.ready;
    out_blocked = out_valid_q && !out_o.ready;
    put         = (ctrl.op == rmc_pkg::OP_PUT) && !out_blocked;
    if (put) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  rmc_sequencer u_sequencer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .flags_i       (flags),
    .beat_i        (beat),
    .out_blocked_i (out_blocked),
    .ctrl_o        (ctrl)
  );

  rmc_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .beat_i    (beat),
    .action_i  (in_i.action),
    .value_i   (in_i.value),
    .enc_exp_i (enc_exp_q),
    .dec_exp_i (dec_exp_q),
    .modulus_i (modulus_q),
    .flags_o   (flags),
    .result_o  (dp_result),
    .status_o  (dp_status)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (put) begin
      out_result_q <= dp_result;
      out_status_q <= dp_status;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.result = out_result_q;
  assign out_o.status = out_status_q;

endmodule
